@@ rtl/sccb_pkg.sv @@
// Shared types and constants for the SCCB register write master.
// Holds bus phase codes, sequencer state and result structs; no dependencies.
`timescale 1ns / 1ps

package sccb_pkg;

    localparam int NumBytes    = 3;
    localparam int BitsPerByte = 8;

    // Reset values of the configuration registers
    localparam logic [7:0] RESET_ATTEMPTS   = 8'd20;
    localparam logic [7:0] RESET_WAIT_TICKS = 8'd1;

    // Configuration register indexes
    localparam logic [7:0] CFG_MAX_ATTEMPTS = 8'd0;
    localparam logic [7:0] CFG_WAIT_TICKS   = 8'd1;

    // Request kinds
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // Bus phase codes
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_START_A  = 4'd1;
    localparam logic [3:0] PH_START_B  = 4'd2;
    localparam logic [3:0] PH_BIT_SET  = 4'd3;
    localparam logic [3:0] PH_BIT_HIGH = 4'd4;
    localparam logic [3:0] PH_BIT_LOW  = 4'd5;
    localparam logic [3:0] PH_ACK_SET  = 4'd6;
    localparam logic [3:0] PH_ACK_HIGH = 4'd7;
    localparam logic [3:0] PH_ACK_LOW  = 4'd8;
    localparam logic [3:0] PH_ACK_NACK = 4'd9;
    localparam logic [3:0] PH_STOP_A   = 4'd10;
    localparam logic [3:0] PH_STOP_B   = 4'd11;
    localparam logic [3:0] PH_STOP_C   = 4'd12;

    // Line levels: scl, sda, sda driven
    localparam logic [2:0] LINES_IDLE = 3'b111;

    typedef struct packed {
        logic [3:0]       phase;
        logic [2:0]       bit_count;
        logic [1:0]       byte_index;
        logic [7:0]       shift;
        logic [2:0][7:0]  latched;
        logic [7:0]       attempt_count;
        logic [7:0]       wait_count;
        logic [2:0]       lines;
    } seq_state_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_driven;
        logic       busy;
        logic       done;
        logic       write_ok;
        logic [7:0] attempts_used;
    } seq_result_t;

endpackage

@@ rtl/sccb_register_write_master_top.sv @@
// SCCB register write master: the result of a transaction is
// registered and offered on the clock after the input is accepted.
// Throughput 1 transaction per cycle; the single output register is the only
// stage, and input is taken whenever it is empty or being drained.
// Reset: sequencer idle, lines SCL high and SDA high driven, max_attempts 20,
// wait_ticks 1, no result pending.
// Depends on sccb_pkg and sccb_seq_step.
`timescale 1ns / 1ps

module sccb_register_write_master_top
    import sccb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // config write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data,
    // input channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       req_type,
    input  logic [7:0] device_id,
    input  logic [7:0] reg_address,
    input  logic [7:0] write_data,
    input  logic       sda_sense,
    // output channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic       scl_level,
    output logic       sda_level,
    output logic       sda_driven,
    output logic       busy_res,
    output logic       done_res,
    output logic       write_ok,
    output logic [7:0] attempts_used
);

    seq_state_t  state_reg;
    seq_state_t  state_next;
    seq_result_t res_reg;
    seq_result_t res_next;
    logic        out_valid_reg;
    logic [7:0]  max_attempts_reg;
    logic [7:0]  wait_ticks_reg;
    logic        in_accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_attempts_reg <= RESET_ATTEMPTS;
            wait_ticks_reg   <= RESET_WAIT_TICKS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAX_ATTEMPTS: max_attempts_reg <= cfg_data;
                CFG_WAIT_TICKS:   wait_ticks_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    sccb_seq_step u_step (
        .cur          (state_reg),
        .req_type     (req_type),
        .device_id    (device_id),
        .reg_address  (reg_address),
        .write_data   (write_data),
        .sda_sense    (sda_sense),
        .max_attempts (max_attempts_reg),
        .wait_ticks   (wait_ticks_reg),
        .nxt          (state_next),
        .res          (res_next)
    );

    // Sequencer state advances on every accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase         <= PH_IDLE;
            state_reg.bit_count     <= 3'd0;
            state_reg.byte_index    <= 2'd0;
            state_reg.shift         <= 8'd0;
            state_reg.latched       <= '0;
            state_reg.attempt_count <= 8'd0;
            state_reg.wait_count    <= 8'd0;
            state_reg.lines         <= LINES_IDLE;
        end
        else if (in_accept)
        begin
            state_reg <= state_next;
        end
    end

    // Output register and its valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            res_reg <= res_next;
    end

    assign out_valid     = out_valid_reg;
    assign scl_level     = res_reg.scl_level;
    assign sda_level     = res_reg.sda_level;
    assign sda_driven    = res_reg.sda_driven;
    assign busy_res      = res_reg.busy;
    assign done_res      = res_reg.done;
    assign write_ok      = res_reg.write_ok;
    assign attempts_used = res_reg.attempts_used;

`ifndef SYNTH
    // A finished transaction reports not busy
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done reported while still busy");

    // Success is only flagged together with done
    a_ok_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_ok |-> done_res)
        else $error("write_ok without done");

    // Idle sequencer leaves the bus released
    a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_IDLE |-> state_reg.lines == LINES_IDLE)
        else $error("bus lines not idle while sequencer idle");

    // Start request while idle begins the first attempt
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && req_type == REQ_START && state_reg.phase == PH_IDLE
        |=> state_reg.phase == PH_START_A && state_reg.attempt_count == 8'd1)
        else $error("start request did not begin a transaction");
`endif

endmodule

@@ rtl/sccb_seq_step.sv @@
// Next-state logic of the SCCB write sequencer: one transaction in, one step out.
// Depends on sccb_pkg for phase codes and the state/result structs.
`timescale 1ns / 1ps

module sccb_seq_step
    import sccb_pkg::*;
(
    input  seq_state_t  cur,
    input  logic        req_type,
    input  logic [7:0]  device_id,
    input  logic [7:0]  reg_address,
    input  logic [7:0]  write_data,
    input  logic        sda_sense,
    input  logic [7:0]  max_attempts,
    input  logic [7:0]  wait_ticks,
    output seq_state_t  nxt,
    output seq_result_t res
);

    logic       busy;
    logic       done;
    logic       ok;
    logic       load;
    logic       upd;
    logic [8:0] wait_sum;
    logic       sda_bit;

    always_comb
    begin
        nxt      = cur;
        done     = 1'b0;
        ok       = 1'b0;
        load     = 1'b0;
        upd      = 1'b0;
        busy     = (cur.phase != PH_IDLE);
        wait_sum = {1'b0, cur.wait_count} + 9'd1;
        sda_bit  = 1'b0;

        if (req_type == REQ_START)
        begin
            // Start request is taken only while idle
            if (!busy)
            begin
                nxt.latched[0]    = device_id;
                nxt.latched[1]    = reg_address;
                nxt.latched[2]    = write_data;
                nxt.byte_index    = 2'd0;
                nxt.bit_count     = 3'd0;
                nxt.attempt_count = 8'd1;
                nxt.wait_count    = 8'd0;
                nxt.phase         = PH_START_A;
                upd               = 1'b1;
            end
        end
        else if (busy)
        begin
            // Tick: count out the wait period, then step the bus
            if (wait_sum < {1'b0, wait_ticks})
            begin
                nxt.wait_count = wait_sum[7:0];
            end
            else
            begin
                nxt.wait_count = 8'd0;
                upd            = 1'b1;
                case (cur.phase)
                    PH_START_A:  nxt.phase = PH_START_B;
                    PH_START_B:  load = 1'b1;
                    PH_BIT_SET:  nxt.phase = PH_BIT_HIGH;
                    PH_BIT_HIGH: nxt.phase = PH_BIT_LOW;
                    PH_BIT_LOW:
                    begin
                        nxt.shift = {cur.shift[6:0], 1'b0};
                        if (cur.bit_count == 3'(BitsPerByte - 1))
                        begin
                            nxt.bit_count = 3'd0;
                            nxt.phase     = PH_ACK_SET;
                        end
                        else
                        begin
                            nxt.bit_count = cur.bit_count + 3'd1;
                            nxt.phase     = PH_BIT_SET;
                        end
                    end
                    PH_ACK_SET:  nxt.phase = PH_ACK_HIGH;
                    PH_ACK_HIGH:
                    begin
                        if (sda_sense)
                        begin
                            nxt.phase = PH_ACK_NACK;
                        end
                        else
                        begin
                            nxt.byte_index = cur.byte_index + 2'd1;
                            nxt.phase      = PH_ACK_LOW;
                        end
                    end
                    PH_ACK_LOW:
                    begin
                        if (cur.byte_index >= 2'(NumBytes))
                            nxt.phase = PH_STOP_A;
                        else
                            load = 1'b1;
                    end
                    PH_ACK_NACK: nxt.phase = PH_STOP_A;
                    PH_STOP_A:   nxt.phase = PH_STOP_B;
                    PH_STOP_B:   nxt.phase = PH_STOP_C;
                    PH_STOP_C:
                    begin
                        // All bytes acked or attempts used up ends the transaction
                        if (cur.byte_index >= 2'(NumBytes) || cur.attempt_count >= max_attempts)
                        begin
                            done      = 1'b1;
                            ok        = (cur.byte_index >= 2'(NumBytes));
                            nxt.phase = PH_IDLE;
                        end
                        else
                        begin
                            nxt.attempt_count = cur.attempt_count + 8'd1;
                            nxt.byte_index    = 2'd0;
                            nxt.bit_count     = 3'd0;
                            nxt.phase         = PH_START_A;
                        end
                    end
                    default:     nxt.phase = PH_IDLE;
                endcase
            end
        end

        // Load the next byte into the shifter
        if (load)
        begin
            case (nxt.byte_index)
                2'd0:    nxt.shift = nxt.latched[0];
                2'd1:    nxt.shift = nxt.latched[1];
                2'd2:    nxt.shift = nxt.latched[2];
                default: nxt.shift = 8'd0;
            endcase
            nxt.bit_count = 3'd0;
            nxt.phase     = PH_BIT_SET;
        end

        // Line levels follow the phase after a step
        if (upd)
        begin
            sda_bit = nxt.shift[7];
            case (nxt.phase)
                PH_START_A:  nxt.lines = 3'b111;
                PH_START_B:  nxt.lines = 3'b101;
                PH_BIT_SET:  nxt.lines = {1'b0, sda_bit, 1'b1};
                PH_BIT_HIGH: nxt.lines = {1'b1, sda_bit, 1'b1};
                PH_BIT_LOW:  nxt.lines = {1'b0, sda_bit, 1'b1};
                PH_ACK_SET:  nxt.lines = 3'b010;
                PH_ACK_HIGH: nxt.lines = 3'b110;
                PH_ACK_LOW:  nxt.lines = 3'b010;
                PH_ACK_NACK: nxt.lines = 3'b010;
                PH_STOP_A:   nxt.lines = 3'b001;
                PH_STOP_B:   nxt.lines = 3'b101;
                default:     nxt.lines = LINES_IDLE;
            endcase
        end
    end

    // Result fields come from the updated state
    assign res.scl_level     = nxt.lines[2];
    assign res.sda_level     = nxt.lines[1];
    assign res.sda_driven    = nxt.lines[0];
    assign res.busy          = (nxt.phase != PH_IDLE);
    assign res.done          = done;
    assign res.write_ok      = done & ok;
    assign res.attempts_used = nxt.attempt_count;

endmodule
